>>> rtl/fixed_length_frame_receiver_assert.svh
// Assertion macros used by the checker of the frame receiver.
`ifndef FIXED_LENGTH_FRAME_RECEIVER_ASSERT_SVH
`define FIXED_LENGTH_FRAME_RECEIVER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FLFR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FLFR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/flfr_pkg.sv
// Types and constants shared by the frame receiver modules.
package flfr_pkg;

    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_HEAD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TAIL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEN  = 2'd2;

    localparam logic [BYTE_W-1:0] HEAD_RESET = 8'd0;
    localparam logic [BYTE_W-1:0] TAIL_RESET = 8'd0;
    localparam logic [LEN_W-1:0]  LEN_RESET  = 7'd8;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic store;     // write rx_byte at the fill position
        logic fill_one;  // fill position becomes one
        logic fill_inc;  // fill position advances
        logic fill_clr;  // fill position returns to zero
        logic rd_clr;    // read pointer returns to zero
        logic rd_inc;    // read pointer advances
        logic rd_issue;  // read the store into the output register
    } flfr_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic len_bad;     // frame length is zero or larger than the store
        logic head_match;
        logic tail_match;
        logic overrun;     // fill position already at or past the end
        logic at_final;    // fill position is the final byte of the frame
        logic shown_last;  // the byte on the output is the final one
    } flfr_stat_t;

endpackage

>>> rtl/flfr_dp.sv
// Datapath of the frame receiver: registers, fill and read pointers, frame store.
module flfr_dp
    import flfr_pkg::*;
#(
    parameter int MAX_FRAME = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [BYTE_W-1:0]     rx_byte,
    input  flfr_cmd_t             cmd,
    output flfr_stat_t            stat,
    output logic [BYTE_W-1:0]     frame_byte,
    output logic                  frame_last
);

    localparam int IDX_W = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;
    localparam int CNT_W = $clog2(MAX_FRAME + 1);
    localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

    logic [BYTE_W-1:0] head_reg;
    logic [BYTE_W-1:0] tail_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [CNT_W-1:0]  fill_reg;
    logic [CNT_W-1:0]  fill_next;
    logic [IDX_W-1:0]  rd_idx_reg;
    logic [IDX_W-1:0]  rd_idx_next;
    logic [BYTE_W-1:0] byte_reg;
    logic              last_reg;

    logic [BYTE_W-1:0] frame_mem [MAX_FRAME];

    logic [CMP_W-1:0] len_cmp;
    logic [CMP_W-1:0] fill_cmp;
    logic [CMP_W-1:0] rd_cmp;
    logic [CMP_W-1:0] max_cmp;
    logic [CMP_W-1:0] final_cmp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= HEAD_RESET;
            tail_reg <= TAIL_RESET;
            len_reg  <= LEN_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_HEAD: head_reg <= cfg_data[BYTE_W-1:0];
                REG_TAIL: tail_reg <= cfg_data[BYTE_W-1:0];
                REG_LEN:  len_reg  <= cfg_data[LEN_W-1:0];
                default:  ;
            endcase
        end
    end

    always_comb
    begin
        priority if (cmd.fill_clr)
            fill_next = '0;
        else if (cmd.fill_one)
            fill_next = CNT_W'(1);
        else if (cmd.fill_inc)
            fill_next = fill_reg + CNT_W'(1);
        else
            fill_next = fill_reg;
    end

    always_comb
    begin
        priority if (cmd.rd_clr)
            rd_idx_next = '0;
        else if (cmd.rd_inc)
            rd_idx_next = rd_idx_reg + IDX_W'(1);
        else
            rd_idx_next = rd_idx_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= '0;
            rd_idx_reg <= '0;
        end
        else
        begin
            fill_reg   <= fill_next;
            rd_idx_reg <= rd_idx_next;
        end
    end

    assign len_cmp   = CMP_W'(len_reg);
    assign fill_cmp  = CMP_W'(fill_reg);
    assign rd_cmp    = CMP_W'(rd_idx_reg);
    assign max_cmp   = CMP_W'(MAX_FRAME);
    assign final_cmp = len_cmp - CMP_W'(1);

    // The controller only stores while the fill position is inside the store.
    always_ff @(posedge clk)
    begin
        if (cmd.store)
            frame_mem[fill_reg[IDX_W-1:0]] <= rx_byte;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_issue)
        begin
            byte_reg <= frame_mem[rd_idx_reg];
            last_reg <= (rd_cmp == final_cmp);
        end
    end

    always_comb
    begin
        stat.len_bad    = (len_reg == '0) || (len_cmp > max_cmp);
        stat.head_match = (rx_byte == head_reg);
        stat.tail_match = (rx_byte == tail_reg);
        stat.overrun    = (fill_cmp >= len_cmp) || (fill_cmp >= max_cmp);
        stat.at_final   = (fill_cmp == final_cmp);
        stat.shown_last = last_reg;
    end

    assign frame_byte = byte_reg;
    assign frame_last = last_reg;

endmodule

>>> rtl/flfr_ctrl.sv
// Controller of the frame receiver: hunting, collecting and frame read-out.
module flfr_ctrl
    import flfr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    input  flfr_stat_t stat,
    output flfr_cmd_t  cmd
);

    localparam logic [1:0] ST_HUNT    = 2'd0;
    localparam logic [1:0] ST_COLLECT = 2'd1;
    localparam logic [1:0] ST_READ    = 2'd2;
    localparam logic [1:0] ST_SHOW    = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       take;

    assign in_stall  = (state_reg == ST_READ) || (state_reg == ST_SHOW);
    assign out_valid = (state_reg == ST_SHOW);
    assign take      = in_valid && !in_stall && !stat.len_bad;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_HUNT:
            begin
                // The fill position is always zero while hunting.
                if (take && stat.head_match)
                begin
                    cmd.store    = 1'b1;
                    cmd.fill_one = 1'b1;
                    state_next   = ST_COLLECT;
                end
            end
            ST_COLLECT:
            begin
                if (take)
                begin
                    if (stat.overrun)
                    begin
                        cmd.fill_clr = 1'b1;
                        state_next   = ST_HUNT;
                    end
                    else
                    begin
                        cmd.store = 1'b1;
                        if (stat.at_final)
                        begin
                            cmd.fill_clr = 1'b1;
                            cmd.rd_clr   = 1'b1;
                            state_next   = stat.tail_match ? ST_READ : ST_HUNT;
                        end
                        else
                        begin
                            cmd.fill_inc = 1'b1;
                        end
                    end
                end
            end
            ST_READ:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_SHOW;
            end
            ST_SHOW:
            begin
                if (!out_stall)
                begin
                    if (stat.shown_last)
                    begin
                        state_next = ST_HUNT;
                    end
                    else
                    begin
                        cmd.rd_inc = 1'b1;
                        state_next = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_HUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_HUNT;
        else
            state_reg <= state_next;
    end

endmodule

>>> rtl/fixed_length_frame_receiver.sv
// Top level of the fixed-length frame receiver.
// Bytes are taken one per cycle while hunting for the head byte and while
// collecting a frame. When the final byte matches the tail byte, input
// requests are stalled and the stored frame is sent out head first, each
// byte by a frame store read into the output register, then the output
// request, which is held while out_stall is high. A frame with a wrong tail,
// or one cut short by a byte beyond the frame length, is dropped without
// output. The frame store needs no clearing after reset. Lengths of zero or
// above MAX_FRAME make the block ignore every byte; a length of one never
// completes.
module fixed_length_frame_receiver
    import flfr_pkg::*;
#(
    parameter int MAX_FRAME = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [BYTE_W-1:0]     rx_byte,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [BYTE_W-1:0]     frame_byte,
    output logic                  frame_last
);

    flfr_cmd_t  cmd;
    flfr_stat_t stat;

    flfr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    flfr_dp #(
        .MAX_FRAME (MAX_FRAME)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .rx_byte    (rx_byte),
        .cmd        (cmd),
        .stat       (stat),
        .frame_byte (frame_byte),
        .frame_last (frame_last)
    );

endmodule

>>> rtl/flfr_checker.sv
// Port-level checker of the frame receiver and its bind to the top level.
`include "fixed_length_frame_receiver_assert.svh"

module flfr_checker
    import flfr_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_stall,
    input logic                  out_valid,
    input logic                  out_stall,
    input logic [BYTE_W-1:0]     frame_byte,
    input logic                  frame_last
);

    `FLFR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(frame_byte) && $stable(frame_last), "stalled output request changed")
    `FLFR_ASSERT_SAME(a_no_input_in_readout, out_valid, in_stall, "input taken during frame read-out")
    `FLFR_ASSERT_NEXT(a_readout_continues, out_valid && !out_stall && !frame_last, in_stall, "read-out ended before the final byte")
    `FLFR_ASSERT_NEXT(a_hunt_after_last, out_valid && !out_stall && frame_last, !in_stall && !out_valid, "block not back to hunting after the final byte")

endmodule

bind fixed_length_frame_receiver flfr_checker u_flfr_checker (.*);
